// ----- sv/ihc_pkg.sv -----
// Shared types, codes and defaults for the idle handle cache.
// Used by ihc_cfg and the top level; depends on nothing.
package ihc_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int SOFT_LIMIT_RESET = 64;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ERASE   = 2'd2,
    OP_POP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_NONE     = 2'd1,
    RES_FULL     = 2'd2,
    RES_BAD_SLOT = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_USED = 2'd1,
    SLOT_IDLE = 2'd2
  } slot_state_t;

  typedef enum logic {
    REG_SOFT_LIMIT = 1'b0,
    REG_IDLE_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_UNLINK,
    S_SCAN,
    S_CLAIM,
    S_CHECK,
    S_APPEND,
    S_LINK,
    S_POP_RD,
    S_POP_CHK,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [6:0]  soft_entry_limit;
    logic [30:0] idle_timeout_ms;
  } cfg_t;

endpackage

// ----- sv/ihc_ram.sv -----
// Simple dual-port memory with one write port and one registered read port.
// Depends on nothing.
module ihc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ihc_cfg.sv -----
// APB register file holding the soft entry limit and the idle timeout.
// Depends on ihc_pkg.
module ihc_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output ihc_pkg::cfg_t cfg
);
  import ihc_pkg::*;

  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.soft_entry_limit <= 7'(SOFT_LIMIT_RESET);
      cfg.idle_timeout_ms <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SOFT_LIMIT:   cfg.soft_entry_limit <= pwdata[6:0];
        REG_IDLE_TIMEOUT: cfg.idle_timeout_ms <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOFT_LIMIT:   prdata = {25'd0, cfg.soft_entry_limit};
      REG_IDLE_TIMEOUT: prdata = {1'b0, cfg.idle_timeout_ms};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- sv/idle_handle_cache_lru_timeout.sv -----
// Top level of the idle handle cache: sequencer, slot state and link memories.
// Depends on ihc_pkg, ihc_ram and ihc_cfg.
//
// Usage. Requests arrive as beats on the input channel (in_valid/in_ready)
// carrying opcode, inode_key, handle_slot and now_ms. Every request yields
// exactly one result beat on the output channel (out_valid/out_ready) with
// status, result_slot, reused and popped_inode. The APB port sets the soft
// entry limit (address 0) and the idle timeout (address 4); write it only
// while no request is in flight.
// Sequencing. The block works on one request at a time and drops in_ready
// while busy. Release checks the handle, then appends the slot to the idle
// list and links it (a bad handle stops after the check); erase checks and
// frees the slot; pop reads the list head, checks its age and unlinks it if
// expired. Acquire walks the idle list, a memory read and then the key
// compare per entry, and, with no match, scans the slot states one per cycle.
// Reset. Synchronous reset marks all slots free, empties the idle list and
// clears the occupied count; the slot memories need no clearing.
// Stalls. A result sits in an output register; the next request is accepted
// and processed meanwhile, and its own result waits in the sequencer until
// the output register has been taken.
module idle_handle_cache_lru_timeout #(
  parameter int SLOTS = ihc_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] inode_key,
  input  logic [5:0]  handle_slot,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  result_slot,
  output logic        reused,
  output logic [31:0] popped_inode,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ihc_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  cfg_t cfg;

  ihc_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // Slot states live in flip-flops so that reset frees every slot at once.
  slot_state_t slot_state [SLOTS];

  fsm_t state, state_next;

  op_t            op;
  logic [31:0]    key;
  logic [31:0]    now;
  logic [5:0]     hnd;
  logic [PW-1:0]  head, tail, cur, prv, nxt;
  logic [SW-1:0]  found, idx;
  logic [PW-1:0]  occ;
  logic           pop_mode;

  logic [1:0]     res_status;
  logic [SW-1:0]  res_slot;
  logic           res_reused;
  logic [31:0]    res_inode;

  // Memory ports.
  logic [SW-1:0]  raddr;
  logic [31:0]    inode_rd, stamp_rd;
  logic [PW-1:0]  next_rd, prev_rd;
  logic           inode_we, stamp_we, next_we, prev_we;
  logic [SW-1:0]  inode_wa, stamp_wa, next_wa, prev_wa;
  logic [31:0]    stamp_wd;
  logic [PW-1:0]  next_wd, prev_wd;

  ihc_ram #(.DEPTH(SLOTS), .WIDTH(32)) u_inode (
    .clk(clk), .we(inode_we), .waddr(inode_wa), .wdata(key),
    .raddr(raddr), .rdata(inode_rd)
  );
  ihc_ram #(.DEPTH(SLOTS), .WIDTH(32)) u_stamp (
    .clk(clk), .we(stamp_we), .waddr(stamp_wa), .wdata(stamp_wd),
    .raddr(raddr), .rdata(stamp_rd)
  );
  ihc_ram #(.DEPTH(SLOTS), .WIDTH(PW)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(raddr), .rdata(next_rd)
  );
  ihc_ram #(.DEPTH(SLOTS), .WIDTH(PW)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(raddr), .rdata(prev_rd)
  );

  logic [31:0]   hnd_wide;
  logic [SW-1:0] hnd_idx;
  logic          hnd_bad;
  logic [31:0]   age, limit;
  logic          expired;
  logic          key_hit;
  logic          out_free;
  logic [31:0]   res_slot_wide;

  assign hnd_wide = 32'(hnd);
  assign hnd_idx  = hnd_wide[SW-1:0];
  assign hnd_bad  = (hnd_wide >= 32'(SLOTS)) || (slot_state[hnd_idx] != SLOT_USED);

  // Separate compare units: idle age against the timeout in pop, and the
  // inode key against the stored key during the list walk.
  assign age     = now - stamp_rd;
  assign limit   = (32'(occ) > 32'(cfg.soft_entry_limit)) ? 32'd0
                 : {1'b0, cfg.idle_timeout_ms};
  assign expired = age >= limit;
  assign key_hit = inode_rd == key;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;
  assign res_slot_wide = 32'(res_slot);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(opcode))
            OP_ACQUIRE: state_next = S_WALK_RD;
            OP_POP:     state_next = S_POP_RD;
            default:    state_next = S_CHECK;
          endcase
        end
      end
      S_WALK_RD:  state_next = (cur == NIL) ? S_SCAN : S_WALK_CHK;
      S_WALK_CHK: state_next = key_hit ? S_UNLINK : S_WALK_RD;
      S_UNLINK:   state_next = pop_mode ? S_DONE : S_CLAIM;
      S_SCAN: begin
        if (slot_state[idx] == SLOT_FREE) begin
          state_next = S_CLAIM;
        end else if (idx == LAST) begin
          state_next = S_DONE;
        end
      end
      S_CLAIM:   state_next = S_DONE;
      S_CHECK: begin
        if (hnd_bad || op == OP_ERASE) begin
          state_next = S_DONE;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND:  state_next = S_LINK;
      S_LINK:    state_next = S_DONE;
      S_POP_RD:  state_next = (head == NIL) ? S_DONE : S_POP_CHK;
      S_POP_CHK: state_next = expired ? S_UNLINK : S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    raddr    = cur[SW-1:0];
    inode_we = 1'b0;
    stamp_we = 1'b0;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    inode_wa = found;
    stamp_wa = found;
    next_wa  = prv[SW-1:0];
    prev_wa  = nxt[SW-1:0];
    stamp_wd = now;
    next_wd  = nxt;
    prev_wd  = prv;
    case (state)
      S_POP_RD: raddr = head[SW-1:0];
      S_UNLINK: begin
        next_we = prv != NIL;
        prev_we = nxt != NIL;
      end
      S_CLAIM: begin
        inode_we = 1'b1;
        stamp_we = 1'b1;
      end
      S_APPEND: begin
        stamp_we = 1'b1;
        stamp_wa = hnd_idx;
        prev_we  = 1'b1;
        prev_wa  = hnd_idx;
        prev_wd  = tail;
        next_we  = 1'b1;
        next_wa  = hnd_idx;
        next_wd  = NIL;
      end
      S_LINK: begin
        next_we = tail != NIL;
        next_wa = tail[SW-1:0];
        next_wd = PW'(hnd_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NIL;
      tail  <= NIL;
      occ   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= SLOT_FREE;
      end
    end else begin
      state <= state_next;
      // A finished result enters the output register when it is empty or as the old beat leaves.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op  <= op_t'(opcode);
            key <= inode_key;
            hnd <= handle_slot;
            now <= now_ms;
            cur <= head;
            idx <= '0;
            pop_mode   <= 1'b0;
            res_status <= RES_OK;
            res_slot   <= '0;
            res_reused <= 1'b0;
            res_inode  <= '0;
          end
        end
        S_WALK_CHK: begin
          if (key_hit) begin
            found <= cur[SW-1:0];
            prv   <= prev_rd;
            nxt   <= next_rd;
          end else begin
            cur <= next_rd;
          end
        end
        S_UNLINK: begin
          if (prv == NIL) head <= nxt;
          if (nxt == NIL) tail <= prv;
          if (pop_mode) begin
            slot_state[found] <= SLOT_FREE;
            if (occ != '0) occ <= occ - 1'b1;
            res_slot <= found;
          end else begin
            res_reused <= 1'b1;
          end
        end
        S_SCAN: begin
          if (slot_state[idx] == SLOT_FREE) begin
            found <= idx;
            occ   <= occ + 1'b1;
          end else if (idx == LAST) begin
            res_status <= RES_FULL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CLAIM: begin
          slot_state[found] <= SLOT_USED;
          res_slot <= found;
        end
        S_CHECK: begin
          if (hnd_bad) begin
            res_status <= RES_BAD_SLOT;
          end else if (op == OP_ERASE) begin
            slot_state[hnd_idx] <= SLOT_FREE;
            if (occ != '0) occ <= occ - 1'b1;
          end else begin
            slot_state[hnd_idx] <= SLOT_IDLE;
          end
        end
        S_LINK: begin
          if (tail == NIL) head <= PW'(hnd_idx);
          tail <= PW'(hnd_idx);
        end
        S_POP_RD: begin
          if (head == NIL) res_status <= RES_NONE;
        end
        S_POP_CHK: begin
          if (expired) begin
            pop_mode  <= 1'b1;
            found     <= head[SW-1:0];
            prv       <= prev_rd;
            nxt       <= next_rd;
            res_inode <= inode_rd;
          end else begin
            res_status <= RES_NONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            status       <= res_status;
            result_slot  <= res_slot_wide[5:0];
            reused       <= res_reused;
            popped_inode <= res_inode;
          end
        end
        default: ;
      endcase
    end
  end

  // The idle list is empty at both ends or at neither.
  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    (head == NIL) == (tail == NIL))
    else $error("idle list head and tail disagree on emptiness");

  // The occupied count never exceeds the number of slots.
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= 32'(SLOTS))
    else $error("occupied count out of range");

  // A failed request reports slot zero and no inode.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != RES_OK |-> result_slot == 6'd0 && popped_inode == 32'd0)
    else $error("failed result carries a slot or inode");

  // Reuse is only reported on a successful acquire.
  a_reuse_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && reused |-> status == RES_OK && popped_inode == 32'd0)
    else $error("reuse flagged on a failed or pop result");

  // A new result is loaded only into an empty or departing output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !out_ready |=> $stable(status) && out_valid)
    else $error("pending result overwritten");

endmodule
